// ----- hw/rtl/tv2t_pkg.sv -----
package tv2t_pkg;

    // Calibration table geometry and field widths.
    localparam int TABLE_ENTRIES    = 27;
    localparam int IDX_W            = $clog2(TABLE_ENTRIES);
    localparam int CAL_DEPTH        = 2 ** IDX_W;
    localparam int MV_W             = 12;
    localparam int TEMP_W           = 9;
    localparam int VOLTAGE_BITS_DEF = 12;

    // Interpolation datapath widths.
    localparam int NUM_W = MV_W + TEMP_W;
    localparam int CNT_W = $clog2(TEMP_W);

    localparam logic [IDX_W-1:0] FIRST_IDX = '0;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic [MV_W-1:0]   mv;
        logic [TEMP_W-1:0] temp;
    } t_cal_point;

    // NTC 100k B3950 with a 10k pull-up at 3.3 V, falling voltage, 10 degree steps.
    // Entries past the last point repeat it and are never selected.
    localparam t_cal_point CAL_TABLE [CAL_DEPTH] = '{
        '{12'd3201, 9'd0  }, '{12'd3142, 9'd10 }, '{12'd3055, 9'd20 }, '{12'd2934, 9'd30 },
        '{12'd2775, 9'd40 }, '{12'd2577, 9'd50 }, '{12'd2346, 9'd60 }, '{12'd2090, 9'd70 },
        '{12'd1823, 9'd80 }, '{12'd1556, 9'd90 }, '{12'd1306, 9'd100}, '{12'd1083, 9'd110},
        '{12'd891,  9'd120}, '{12'd724,  9'd130}, '{12'd583,  9'd140}, '{12'd471,  9'd150},
        '{12'd383,  9'd160}, '{12'd313,  9'd170}, '{12'd256,  9'd180}, '{12'd209,  9'd190},
        '{12'd172,  9'd200}, '{12'd144,  9'd210}, '{12'd121,  9'd220}, '{12'd102,  9'd230},
        '{12'd85,   9'd240}, '{12'd72,   9'd250}, '{12'd61,   9'd260}, '{12'd61,   9'd260},
        '{12'd61,   9'd260}, '{12'd61,   9'd260}, '{12'd61,   9'd260}, '{12'd61,   9'd260}
    };

    // Table search sequencer states.
    typedef enum logic [2:0] {
        SR_IDLE,
        SR_CHK_TOP,
        SR_CHK_END,
        SR_BISECT,
        SR_DONE
    } t_srch_state;

    // Core sequencer states.
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SEARCH,
        CS_FETCH,
        CS_MUL,
        CS_DIV,
        CS_OUT
    } t_core_state;

    // Search outcome: either a clamp to the point at idx, or the segment starting at idx.
    typedef struct packed {
        logic             done;
        logic             clamp;
        logic [IDX_W-1:0] idx;
    } t_srch_result;

endpackage

// ----- hw/rtl/thermistor_voltage_to_temperature_core.sv -----
// Converts one NTC thermistor divider voltage in millivolts into a temperature in whole
// degrees Celsius, by linear interpolation between the two points of a fixed 27-point
// calibration table (100k B3950, 10k pull-up, 3.3 V) that bracket it. Voltages above the
// first point read 0 and voltages below the last point read 260. One request is worked
// on at a time: the input is ready only while the block is idle. A single shared comparator
// checks the table ends, and a clamped request goes straight from there to the result; for an
// interpolated one it then bisects the table (four or five probes and one closing step),
// followed by a segment fetch, one multiply and a nine-step restoring divider. The result
// stays valid until taken, and the next request is accepted in the cycle after it is taken.
module thermistor_voltage_to_temperature_core
    import tv2t_pkg::*;
#(
    parameter int VOLTAGE_BITS = VOLTAGE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [VOLTAGE_BITS-1:0] i_voltage_mv,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [TEMP_W-1:0]       o_temperature_c
);

    localparam int CMP_W = (VOLTAGE_BITS > MV_W) ? VOLTAGE_BITS : MV_W;

    t_core_state             r_state;
    t_core_state             n_state;
    logic [VOLTAGE_BITS-1:0] r_mv;
    logic [IDX_W-1:0]        r_seg;
    logic [MV_W-1:0]         r_diff;
    logic [MV_W-1:0]         r_span;
    logic [TEMP_W-1:0]       r_tdiff;
    logic [TEMP_W-1:0]       r_tlow;
    logic [TEMP_W-1:0]       r_temp;

    logic                    in_acc;
    logic                    div_start;
    logic                    div_done;
    logic [TEMP_W-1:0]       div_quo;
    logic [NUM_W-1:0]        product;
    logic [IDX_W-1:0]        seg_next;
    logic [CMP_W-1:0]        diff_full;
    t_cal_point              pt_high;
    t_cal_point              pt_low;
    t_srch_result            srch;

    assign in_acc = i_in_valid && o_in_ready;

    // Table search over the calibration points.
    tv2t_search #(
        .VOLTAGE_BITS(VOLTAGE_BITS)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_mv    (r_mv),
        .o_result(srch)
    );

    // Bracketing pair of the chosen segment.
    assign seg_next  = r_seg + IDX_W'(1);
    assign pt_high   = CAL_TABLE[r_seg];
    assign pt_low    = CAL_TABLE[seg_next];
    assign diff_full = CMP_W'(pt_high.mv) - CMP_W'(r_mv);

    // Scaled offset into the segment, divided by the segment's voltage span.
    assign product = NUM_W'(r_diff) * NUM_W'(r_tdiff);

    tv2t_divider u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(product),
        .i_divisor (r_span),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE:   if (in_acc) n_state = CS_SEARCH;
            CS_SEARCH: if (srch.done) n_state = srch.clamp ? CS_OUT : CS_FETCH;
            CS_FETCH:  n_state = CS_MUL;
            CS_MUL:    n_state = CS_DIV;
            CS_DIV:    if (div_done) n_state = CS_OUT;
            CS_OUT:    if (i_out_ready) n_state = CS_IDLE;
            default:   n_state = CS_IDLE;
        endcase
    end

    // Handshake and divider launch.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        div_start   = 1'b0;
        unique case (r_state)
            CS_IDLE: o_in_ready  = 1'b1;
            CS_MUL:  div_start   = 1'b1;
            CS_OUT:  o_out_valid = 1'b1;
            default: o_in_ready  = 1'b0;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sample capture, segment operands and result register.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mv <= i_voltage_mv;
        end
        if (r_state == CS_SEARCH && srch.done) begin
            r_seg  <= srch.idx;
            r_temp <= CAL_TABLE[srch.idx].temp;
        end
        if (r_state == CS_FETCH) begin
            r_diff  <= diff_full[MV_W-1:0];
            r_span  <= pt_high.mv - pt_low.mv;
            r_tdiff <= pt_low.temp - pt_high.temp;
            r_tlow  <= pt_high.temp;
        end
        if (r_state == CS_DIV && div_done) begin
            r_temp <= r_tlow + div_quo;
        end
    end

    assign o_temperature_c = r_temp;

    // A new request is never taken while a result is offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    // After acceptance the block stays busy for at least the clamp checks.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready ##1 !o_in_ready)
        else $error("request accepted before the previous one finished");

    // The divider reports completion only while the core waits for it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == CS_DIV))
        else $error("divider completion outside the divide phase");

    // Results stay within the calibrated range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temperature_c <= CAL_TABLE[LAST_IDX].temp))
        else $error("temperature beyond the last calibration point");

endmodule

// ----- hw/rtl/tv2t_search.sv -----
module tv2t_search
    import tv2t_pkg::*;
#(
    parameter int VOLTAGE_BITS = VOLTAGE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [VOLTAGE_BITS-1:0] i_mv,
    output t_srch_result            o_result
);

    localparam int CMP_W = (VOLTAGE_BITS > MV_W) ? VOLTAGE_BITS : MV_W;

    t_srch_state      r_state;
    t_srch_state      n_state;
    logic [IDX_W-1:0] r_lo;
    logic [IDX_W-1:0] r_hi;
    logic [IDX_W-1:0] r_idx;
    logic             r_clamp;

    logic [IDX_W-1:0] cmp_idx;
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;
    logic [CMP_W-1:0] rom_v;
    logic [CMP_W-1:0] mv_x;
    logic             rom_lt;
    logic             rom_le;
    logic             span_one;

    // Midpoint of the remaining candidate range.
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[IDX_W:1];
    assign span_one = (r_lo == r_hi);

    // The single shared comparator: table voltage against the sample.
    assign rom_v  = CMP_W'(CAL_TABLE[cmp_idx].mv);
    assign mv_x   = CMP_W'(i_mv);
    assign rom_lt = (rom_v < mv_x);
    assign rom_le = rom_lt | (rom_v == mv_x);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SR_IDLE:    if (i_start) n_state = SR_CHK_TOP;
            SR_CHK_TOP: n_state = rom_lt ? SR_DONE : SR_CHK_END;
            SR_CHK_END: n_state = rom_le ? SR_BISECT : SR_DONE;
            SR_BISECT:  if (span_one) n_state = SR_DONE;
            SR_DONE:    n_state = SR_IDLE;
            default:    n_state = SR_IDLE;
        endcase
    end

    // Comparator address and result presentation.
    always_comb begin
        cmp_idx  = mid;
        o_result = '{done: 1'b0, clamp: r_clamp, idx: r_idx};
        unique case (r_state)
            SR_CHK_TOP: cmp_idx = FIRST_IDX;
            SR_CHK_END: cmp_idx = LAST_IDX;
            SR_DONE:    o_result.done = 1'b1;
            default:    cmp_idx = mid;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Range bounds and outcome: the clamp point, else the last one above the sample.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            SR_CHK_TOP: begin
                r_clamp <= rom_lt;
                r_idx   <= FIRST_IDX;
            end
            SR_CHK_END: begin
                r_clamp <= ~rom_le;
                r_idx   <= LAST_IDX;
                r_lo    <= IDX_W'(1);
                r_hi    <= LAST_IDX;
            end
            SR_BISECT: begin
                if (span_one) begin
                    r_clamp <= 1'b0;
                    r_idx   <= r_lo - IDX_W'(1);
                end else if (rom_le) begin
                    r_hi <= mid;
                end else begin
                    r_lo <= mid + IDX_W'(1);
                end
            end
            default: begin
                r_clamp <= r_clamp;
            end
        endcase
    end

endmodule

// ----- hw/rtl/tv2t_divider.sv -----
module tv2t_divider
    import tv2t_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_dividend,
    input  logic [MV_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [TEMP_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dsh;
    logic [TEMP_W-1:0] r_quo;
    logic              ge;

    // One restoring step: try the divisor at the current weight.
    assign ge = (r_rem >= r_dsh);

    // Control: busy for one cycle per quotient bit, done for one cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath. The quotient never exceeds the temperature step, so the divisor
    // starts at the weight of the top quotient bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsh <= NUM_W'(i_divisor) << (TEMP_W - 1);
            r_quo <= '0;
            r_cnt <= CNT_W'(TEMP_W - 1);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[TEMP_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
